// ===== rtl/bgi_pkg.sv =====
// Shared constants, codes and width helpers for the bilinear grid interpolator.
`default_nettype none

package bgi_pkg;

  localparam int MAX_ROWS_DEF    = 16;
  localparam int MAX_COLS_DEF    = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF   = 8;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam int POS_BITS     = 16;
  localparam int SEL_BITS     = 4;
  localparam int SIZE_BITS    = 5;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = SIZE_BITS'(16);

  localparam logic [CFG_IDX_BITS-1:0] CFG_ROWS_IN_USE = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLS_IN_USE = CFG_IDX_BITS'(1);

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  // Width of a residual position after the cell is taken off.
  function automatic int resid_bits(int max_rows, int max_cols, int frac_bits);
    int kb;
    int m;
    kb = ($clog2(max_rows) > $clog2(max_cols)) ? $clog2(max_rows) : $clog2(max_cols);
    m  = (POS_BITS > kb + frac_bits) ? POS_BITS : kb + frac_bits;
    return m + 2;
  endfunction

  // Width of one queue entry between the front and the back.
  function automatic int entry_bits(int max_rows, int max_cols, int sample_bits,
                                    int frac_bits);
    return 1 + $clog2(max_rows) + $clog2(max_cols) + sample_bits
           + 2 * resid_bits(max_rows, max_cols, frac_bits);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/bgi_if.sv =====
// Channel interfaces: input items, configuration writes and results.
`default_nettype none

interface bgi_item_if #(
  parameter int SAMPLE_BITS = bgi_pkg::SAMPLE_BITS_DEF
);
  import bgi_pkg::*;

  logic                          valid;
  logic                          ready;
  logic                          opcode;
  logic        [SEL_BITS-1:0]    row_sel;
  logic        [SEL_BITS-1:0]    col_sel;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic signed [POS_BITS-1:0]    row_pos;
  logic signed [POS_BITS-1:0]    col_pos;

  modport source (output valid, opcode, row_sel, col_sel, sample_in, row_pos, col_pos,
                  input ready);
  modport sink (input valid, opcode, row_sel, col_sel, sample_in, row_pos, col_pos,
                output ready);
endinterface

interface bgi_cfg_if;
  import bgi_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [SIZE_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface bgi_result_if #(
  parameter int SAMPLE_BITS = bgi_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] interp_value;
  logic                          saturated;

  modport source (output valid, interp_value, saturated, input ready);
  modport sink (input valid, interp_value, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/bgi_ram.sv =====
// Generic single-port RAM with registered read data.
`default_nettype none

module bgi_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/bgi_queue.sv =====
// Short FIFO between the classifying front and the executing back.
`default_nettype none

module bgi_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             push, pop;

  assign push_ready_o = (count_q != CW'(DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bgi_front.sv =====
// Front end: size registers, item acceptance, cell and residual computation.
`default_nettype none

module bgi_front #(
  parameter int MAX_ROWS    = bgi_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = bgi_pkg::MAX_COLS_DEF,
  parameter int SAMPLE_BITS = bgi_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = bgi_pkg::FRAC_BITS_DEF,
  parameter int EW          = bgi_pkg::entry_bits(MAX_ROWS, MAX_COLS, SAMPLE_BITS, FRAC_BITS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  bgi_item_if.sink      item_i,
  bgi_cfg_if.sink       cfg_i,
  output logic          push_valid_o,
  input  logic          push_ready_i,
  output logic [EW-1:0] push_entry_o
);
  import bgi_pkg::*;

  localparam int RB = $clog2(MAX_ROWS);
  localparam int CB = $clog2(MAX_COLS);
  localparam int KB = (RB > CB) ? RB : CB;
  localparam int CW = ((POS_BITS > KB) ? POS_BITS : KB) + 2;
  localparam int DW = resid_bits(MAX_ROWS, MAX_COLS, FRAC_BITS);

  typedef struct packed {
    logic                          is_query;
    logic        [RB-1:0]          row;
    logic        [CB-1:0]          col;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic signed [DW-1:0]          dr;
    logic signed [DW-1:0]          dc;
  } entry_t;

  logic [SIZE_BITS-1:0] rows_q, rows_d;
  logic [SIZE_BITS-1:0] cols_q, cols_d;
  logic signed [CW-1:0] kr, kc;
  logic                 in_range;
  entry_t               ent;

  function automatic logic signed [CW-1:0] cell_of(logic signed [POS_BITS-1:0] pos,
                                                   logic [SIZE_BITS-1:0] size,
                                                   logic signed [CW-1:0] maxn);
    logic signed [CW-1:0] fl;
    logic signed [CW-1:0] n;
    logic signed [CW-1:0] k;
    fl = CW'(pos);
    fl = fl >>> FRAC_BITS;
    n  = $signed({{(CW - SIZE_BITS){1'b0}}, size});
    if (n < CW'(2)) n = CW'(2);
    if (n > maxn) n = maxn;
    k = fl;
    if (k > n - CW'(2)) k = n - CW'(2);
    if (k < CW'(0)) k = '0;
    return k;
  endfunction

  function automatic logic signed [DW-1:0] resid_of(logic signed [POS_BITS-1:0] pos,
                                                    logic signed [CW-1:0] k);
    logic signed [DW-1:0] p;
    logic signed [DW-1:0] kk;
    p  = DW'(pos);
    kk = DW'(k);
    return p - (kk <<< FRAC_BITS);
  endfunction

  assign cfg_i.ready = 1'b1;

  always_comb begin
    rows_d = rows_q;
    cols_d = cols_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_ROWS_IN_USE: rows_d = cfg_i.data;
        CFG_COLS_IN_USE: cols_d = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= SIZE_RESET;
      cols_q <= SIZE_RESET;
    end else begin
      rows_q <= rows_d;
      cols_q <= cols_d;
    end
  end

  assign kr       = cell_of(item_i.row_pos, rows_q, CW'(MAX_ROWS));
  assign kc       = cell_of(item_i.col_pos, cols_q, CW'(MAX_COLS));
  assign in_range = (int'(item_i.row_sel) < MAX_ROWS) && (int'(item_i.col_sel) < MAX_COLS);

  always_comb begin
    ent.is_query = (item_i.opcode == OP_QUERY);
    ent.sample   = item_i.sample_in;
    if (item_i.opcode == OP_QUERY) begin
      ent.row = kr[RB-1:0];
      ent.col = kc[CB-1:0];
      ent.dr  = resid_of(item_i.row_pos, kr);
      ent.dc  = resid_of(item_i.col_pos, kc);
    end else begin
      ent.row = RB'(item_i.row_sel);
      ent.col = CB'(item_i.col_sel);
      ent.dr  = '0;
      ent.dc  = '0;
    end
  end

  // Drop writes outside the grid: they leave no trace.
  assign item_i.ready = push_ready_i;
  assign push_valid_o = item_i.valid && ((item_i.opcode == OP_QUERY) || in_range);
  assign push_entry_o = ent;

endmodule

`default_nettype wire

// ===== rtl/bgi_back.sv =====
// Back end: grid RAM access, shared multiply-accumulate, rounding and output register.
`default_nettype none

module bgi_back #(
  parameter int MAX_ROWS    = bgi_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = bgi_pkg::MAX_COLS_DEF,
  parameter int SAMPLE_BITS = bgi_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = bgi_pkg::FRAC_BITS_DEF,
  parameter int EW          = bgi_pkg::entry_bits(MAX_ROWS, MAX_COLS, SAMPLE_BITS, FRAC_BITS)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          pop_valid_i,
  output logic          pop_ready_o,
  input  logic [EW-1:0] pop_entry_i,
  bgi_result_if.source  result_o
);
  import bgi_pkg::*;

  localparam int SB  = SAMPLE_BITS;
  localparam int RB  = $clog2(MAX_ROWS);
  localparam int CB  = $clog2(MAX_COLS);
  localparam int DW  = resid_bits(MAX_ROWS, MAX_COLS, FRAC_BITS);
  localparam int WW  = DW + 1;
  localparam int AW  = SB + WW + 1;
  localparam int H   = AW / 2;
  localparam int LB  = AW - H;
  localparam int MA0 = (SB > LB) ? SB : LB;
  localparam int MA  = (MA0 > H + 1) ? MA0 : H + 1;
  localparam int PW  = MA + WW;
  localparam int TW  = AW + WW + 2;
  localparam int ADW = $clog2(MAX_ROWS * MAX_COLS);

  localparam logic signed [WW-1:0] OneW   = WW'(1) << FRAC_BITS;
  localparam logic signed [TW-1:0] RoundT = TW'(1) << (2 * FRAC_BITS - 1);

  localparam logic [3:0] StA0   = 4'd1;
  localparam logic [3:0] StA1   = 4'd2;
  localparam logic [3:0] StB0   = 4'd3;
  localparam logic [3:0] StB1   = 4'd4;
  localparam logic [3:0] StAh   = 4'd5;
  localparam logic [3:0] StAl   = 4'd6;
  localparam logic [3:0] StBh   = 4'd7;
  localparam logic [3:0] StBl   = 4'd8;
  localparam logic [3:0] StLast = 4'd9;

  typedef struct packed {
    logic                 is_query;
    logic        [RB-1:0] row;
    logic        [CB-1:0] col;
    logic signed [SB-1:0] sample;
    logic signed [DW-1:0] dr;
    logic signed [DW-1:0] dc;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_EMIT
  } state_e;

  typedef enum logic [2:0] {
    DST_NONE,
    DST_A,
    DST_B,
    DST_HI,
    DST_LO
  } dst_e;

  entry_t               ent;
  state_e               state_q, state_d;
  logic [3:0]           st_q, st_d;
  logic [RB-1:0]        kr_q, kr_d;
  logic [CB-1:0]        kc_q, kc_d;
  logic signed [WW-1:0] wc0_q, wc0_d, wc1_q, wc1_d;
  logic signed [WW-1:0] wr0_q, wr0_d, wr1_q, wr1_d;
  logic signed [AW-1:0] acc_a_q, acc_a_d, acc_b_q, acc_b_d;
  logic signed [TW-1:0] acc_t_q, acc_t_d;
  logic signed [PW-1:0] prod_q, prod_d;
  dst_e                 dst_q, dst_d;
  logic                 out_valid_q, out_valid_d;
  logic signed [SB-1:0] out_value_q, out_value_d;
  logic                 out_sat_q, out_sat_d;

  logic signed [MA-1:0] mul_a;
  logic signed [WW-1:0] mul_b;
  logic signed [PW-1:0] mul_p;
  dst_e                 mul_dst;

  logic                 pop;
  logic                 ram_we, ram_re;
  logic [ADW-1:0]       ram_addr;
  logic [SB-1:0]        ram_rdata;
  logic [RB-1:0]        rd_row;
  logic [CB-1:0]        rd_col;

  logic signed [TW-1:0] vsh;
  logic [TW-SB:0]       vtop;
  logic                 pos_ovf, neg_ovf;

  function automatic logic [ADW-1:0] grid_addr(logic [RB-1:0] r, logic [CB-1:0] c);
    return ADW'(r) * ADW'(MAX_COLS) + ADW'(c);
  endfunction

  assign ent         = pop_entry_i;
  assign pop_ready_o = (state_q == S_IDLE);
  assign pop         = pop_valid_i && pop_ready_o;

  assign rd_row   = kr_q + RB'(st_q[1]);
  assign rd_col   = kc_q + CB'(st_q[0]);
  assign ram_we   = pop && !ent.is_query;
  assign ram_re   = (state_q == S_RUN) && (st_q < StA0 + 4'd3);
  assign ram_addr = ram_we ? grid_addr(ent.row, ent.col) : grid_addr(rd_row, rd_col);

  bgi_ram #(
    .WIDTH (SB),
    .DEPTH (MAX_ROWS * MAX_COLS)
  ) u_grid (
    .clk_i   (clk_i),
    .en_i    (ram_we || ram_re),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ent.sample),
    .rdata_o (ram_rdata)
  );

  // Shared multiplier operand selection.
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_dst = DST_NONE;
    if (state_q == S_RUN) begin
      case (st_q)
        StA0: begin
          mul_a   = MA'($signed(ram_rdata));
          mul_b   = wc0_q;
          mul_dst = DST_A;
        end
        StA1: begin
          mul_a   = MA'($signed(ram_rdata));
          mul_b   = wc1_q;
          mul_dst = DST_A;
        end
        StB0: begin
          mul_a   = MA'($signed(ram_rdata));
          mul_b   = wc0_q;
          mul_dst = DST_B;
        end
        StB1: begin
          mul_a   = MA'($signed(ram_rdata));
          mul_b   = wc1_q;
          mul_dst = DST_B;
        end
        StAh: begin
          mul_a   = MA'($signed(acc_a_q[AW-1:H]));
          mul_b   = wr0_q;
          mul_dst = DST_HI;
        end
        StAl: begin
          mul_a   = MA'($signed({1'b0, acc_a_q[H-1:0]}));
          mul_b   = wr0_q;
          mul_dst = DST_LO;
        end
        StBh: begin
          mul_a   = MA'($signed(acc_b_q[AW-1:H]));
          mul_b   = wr1_q;
          mul_dst = DST_HI;
        end
        StBl: begin
          mul_a   = MA'($signed({1'b0, acc_b_q[H-1:0]}));
          mul_b   = wr1_q;
          mul_dst = DST_LO;
        end
        default: ;
      endcase
    end
  end

  assign mul_p = mul_a * mul_b;

  // Round half up, then clip to the sample range.
  assign vsh     = acc_t_q >>> (2 * FRAC_BITS);
  assign vtop    = vsh[TW-1:SB-1];
  assign pos_ovf = !vsh[TW-1] && (|vtop);
  assign neg_ovf = vsh[TW-1] && !(&vtop);

  always_comb begin
    state_d     = state_q;
    st_d        = st_q;
    kr_d        = kr_q;
    kc_d        = kc_q;
    wc0_d       = wc0_q;
    wc1_d       = wc1_q;
    wr0_d       = wr0_q;
    wr1_d       = wr1_q;
    acc_a_d     = acc_a_q;
    acc_b_d     = acc_b_q;
    acc_t_d     = acc_t_q;
    prod_d      = mul_p;
    dst_d       = mul_dst;
    out_valid_d = out_valid_q && !result_o.ready;
    out_value_d = out_value_q;
    out_sat_d   = out_sat_q;

    case (dst_q)
      DST_A:   acc_a_d = acc_a_q + AW'(prod_q);
      DST_B:   acc_b_d = acc_b_q + AW'(prod_q);
      DST_HI:  acc_t_d = acc_t_q + (TW'(prod_q) <<< H);
      DST_LO:  acc_t_d = acc_t_q + TW'(prod_q);
      default: ;
    endcase

    unique case (state_q)
      S_IDLE: begin
        if (pop && ent.is_query) begin
          state_d = S_RUN;
          st_d    = '0;
          kr_d    = ent.row;
          kc_d    = ent.col;
          wc1_d   = WW'(ent.dc);
          wc0_d   = OneW - WW'(ent.dc);
          wr1_d   = WW'(ent.dr);
          wr0_d   = OneW - WW'(ent.dr);
          acc_a_d = '0;
          acc_b_d = '0;
          acc_t_d = RoundT;
        end
      end
      S_RUN: begin
        st_d = st_q + 4'd1;
        if (st_q == StLast) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || result_o.ready) begin
          out_valid_d = 1'b1;
          out_sat_d   = pos_ovf || neg_ovf;
          if (pos_ovf) begin
            out_value_d = {1'b0, {(SB - 1){1'b1}}};
          end else if (neg_ovf) begin
            out_value_d = {1'b1, {(SB - 1){1'b0}}};
          end else begin
            out_value_d = vsh[SB-1:0];
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      st_q        <= '0;
      dst_q       <= DST_NONE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      st_q        <= st_d;
      dst_q       <= dst_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kr_q        <= kr_d;
    kc_q        <= kc_d;
    wc0_q       <= wc0_d;
    wc1_q       <= wc1_d;
    wr0_q       <= wr0_d;
    wr1_q       <= wr1_d;
    acc_a_q     <= acc_a_d;
    acc_b_q     <= acc_b_d;
    acc_t_q     <= acc_t_d;
    prod_q      <= prod_d;
    out_value_q <= out_value_d;
    out_sat_q   <= out_sat_d;
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.interp_value = out_value_q;
  assign result_o.saturated    = out_sat_q;

  a_query_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop && ent.is_query |=> state_q == S_RUN && st_q == '0)
    else $error("query transaction did not start the sequencer");

  a_tag_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dst_q != DST_NONE |-> state_q == S_RUN)
    else $error("product pending outside the run state");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RUN && st_q == StLast |=> state_q == S_EMIT)
    else $error("sequencer overran its last step");

  a_emit_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EMIT && !out_valid_q |=> out_valid_q && state_q == S_IDLE)
    else $error("result not loaded into a free output register");

endmodule

`default_nettype wire

// ===== rtl/bilinear_grid_interpolator_top.sv =====
// Top level of the bilinear grid interpolator.
`default_nettype none

// Grid writes and interpolation queries enter on item_i; the front computes the
// clamped cells and residuals and posts each transaction into a four-entry queue,
// so the input keeps taking items while the back end works and the queue has room.
// A write goes to the grid RAM as it is popped. For a query, the single-port grid RAM
// delivers the four neighbors one per cycle while one shared multiplier forms the
// four column products, then the same multiplier forms the four row products on
// split halves of the column sums, and a final emit step rounds, clips and loads the
// output register. The grid RAM has no reset; sizes take effect on the next query.
module bilinear_grid_interpolator_top #(
  parameter int MAX_ROWS    = bgi_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS    = bgi_pkg::MAX_COLS_DEF,
  parameter int SAMPLE_BITS = bgi_pkg::SAMPLE_BITS_DEF,
  parameter int FRAC_BITS   = bgi_pkg::FRAC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  bgi_item_if.sink     item_i,
  bgi_cfg_if.sink      cfg_i,
  bgi_result_if.source result_o
);
  import bgi_pkg::*;

  localparam int EW = entry_bits(MAX_ROWS, MAX_COLS, SAMPLE_BITS, FRAC_BITS);

  logic          push_valid, push_ready;
  logic [EW-1:0] push_entry;
  logic          pop_valid, pop_ready;
  logic [EW-1:0] pop_entry;

  bgi_front #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .EW          (EW)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  bgi_queue #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH_DEF)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_entry)
  );

  bgi_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLS    (MAX_COLS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .FRAC_BITS   (FRAC_BITS),
    .EW          (EW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_entry_i (pop_entry),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire
